// ----- hw/rtl/dsil_pkg.sv -----
// Package for the depth-sorted insertion list: sizes, action and status codes,
// the stored entry type and the control word broadcast to the cell chain.
// No dependencies.
package dsil_pkg;

  // List size and result limits.
  localparam int LIST_DEPTH   = 32;
  localparam int RESULT_LIMIT = 32;
  localparam int CNT_W        = $clog2(LIST_DEPTH + 1);
  localparam int TAG_W        = 16;
  localparam int DIST_W       = 32;
  localparam int ACT_W        = 2;
  localparam int STAT_W       = 2;
  localparam int DATA_W       = 48;

  // Action codes of an input item.
  localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACT_W-1:0] ACT_DRAIN  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd2;

  // Status codes of a result item.
  localparam logic [STAT_W-1:0] STAT_ENTRY    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_INSERTED = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL     = 2'd2;
  localparam logic [STAT_W-1:0] STAT_EMPTY    = 2'd3;

  // Cell operations.
  localparam logic [1:0] CELL_HOLD = 2'd0;
  localparam logic [1:0] CELL_INS  = 2'd1;
  localparam logic [1:0] CELL_ROT  = 2'd2;

  typedef struct packed {
    logic [TAG_W-1:0]         tag;
    logic signed [DIST_W-1:0] distance;
  } entry_t;

  typedef struct packed {
    logic [1:0] op;
    entry_t     ins;
  } cell_ctl_t;

endpackage

// ----- hw/rtl/dsil_cell.sv -----
// One cell of the sorted insertion chain: holds one entry and either keeps it,
// takes the new entry, shifts in its left neighbour or rotates in from the right.
// Depends on dsil_pkg.
module dsil_cell (
  input  logic               clk,
  input  dsil_pkg::cell_ctl_t ctl,
  input  logic               occ,
  input  logic               wrap,
  input  logic               keep_prev,
  input  dsil_pkg::entry_t   left_q,
  input  dsil_pkg::entry_t   right_q,
  input  dsil_pkg::entry_t   head_q,
  output dsil_pkg::entry_t   q,
  output logic               keep
);
  import dsil_pkg::*;

  entry_t ent_r;
  entry_t ent_nxt;

  // An occupied cell whose distance is not below the new key stays put.
  assign keep = occ && (ent_r.distance >= ctl.ins.distance);
  assign q    = ent_r;

  // Next content of the cell.
  always_comb begin
    ent_nxt = ent_r;
    case (ctl.op)
      CELL_INS: begin
        if (keep) begin
          ent_nxt = ent_r;
        end else if (keep_prev) begin
          ent_nxt = ctl.ins;
        end else begin
          ent_nxt = left_q;
        end
      end
      CELL_ROT: begin
        ent_nxt = wrap ? head_q : right_q;
      end
      default: begin
        ent_nxt = ent_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

endmodule

// ----- hw/rtl/depth_sorted_insert_list.sv -----
// Top level of the depth-sorted insertion list: stream ports, entry count,
// drain sequencing, output register and the chain of dsil_cell instances.
// Depends on dsil_pkg and dsil_cell.
//
//   Channel | Direction | Contents
//   in_     | slave     | tuser: action[1:0]; tdata: entry_tag, entry_distance
//   out_    | master    | tuser: status[1:0]; tdata: out_tag, out_distance; tlast: last
//
// An insert or a clear takes effect as it is accepted; every cell compares the new key at once.
// A drain is accepted first; then the chain rotates one place per cycle while the
// output is not stalled, and it ends in its original order. Nothing is
// accepted while a drain runs.
// A stalled output register holds the chain and the input.
// Reset (rst_n low, synchronous) empties the list; stored entries are not cleared.
module depth_sorted_insert_list (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [dsil_pkg::DATA_W-1:0]   in_tdata,   // [15:0] entry_tag, [47:16] entry_distance
  input  logic [dsil_pkg::ACT_W-1:0]    in_tuser,   // [1:0] action
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [dsil_pkg::DATA_W-1:0]   out_tdata,  // [15:0] out_tag, [47:16] out_distance
  output logic [dsil_pkg::STAT_W-1:0]   out_tuser,  // [1:0] status
  output logic                          out_tlast
);
  import dsil_pkg::*;

  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              draining_r, draining_nxt;
  logic [CNT_W-1:0]  drain_idx_r, drain_idx_nxt;
  logic              out_valid_r, out_valid_nxt;
  entry_t            out_ent_r, out_ent_nxt;
  logic [STAT_W-1:0] out_stat_r, out_stat_nxt;
  logic              out_last_r, out_last_nxt;

  cell_ctl_t         ctl;
  entry_t            cell_q [LIST_DEPTH];
  logic              keep   [LIST_DEPTH];

  logic              out_free;
  logic              in_fire;
  logic [CNT_W-1:0]  drain_lim;
  logic              drain_emit;
  logic              drain_step;

  assign out_free   = !out_valid_r || out_tready;
  assign in_tready  = !draining_r && out_free;
  assign in_fire    = in_tvalid && in_tready;
  assign drain_lim  = (count_r > CNT_W'(RESULT_LIMIT)) ? CNT_W'(RESULT_LIMIT) : count_r;
  assign drain_emit = drain_idx_r < drain_lim;
  assign drain_step = draining_r && (!drain_emit || out_free);

  // Control of the list, the drain sequence and the output register.
  always_comb begin
    count_nxt        = count_r;
    draining_nxt     = draining_r;
    drain_idx_nxt    = drain_idx_r;
    out_valid_nxt    = out_valid_r && !out_tready;
    out_ent_nxt      = out_ent_r;
    out_stat_nxt     = out_stat_r;
    out_last_nxt     = out_last_r;
    ctl.op           = CELL_HOLD;
    ctl.ins.tag      = in_tdata[TAG_W-1:0];
    ctl.ins.distance = in_tdata[TAG_W +: DIST_W];

    if (drain_step) begin
      // Stream the head entry out and rotate the chain one place.
      ctl.op        = CELL_ROT;
      drain_idx_nxt = drain_idx_r + 1'b1;
      if (drain_idx_r == count_r - 1'b1) begin
        draining_nxt = 1'b0;
      end
      if (drain_emit) begin
        out_valid_nxt = 1'b1;
        out_ent_nxt   = cell_q[0];
        out_stat_nxt  = STAT_ENTRY;
        out_last_nxt  = (drain_idx_r == drain_lim - 1'b1);
      end
    end else if (in_fire) begin
      out_ent_nxt  = '0;
      out_last_nxt = 1'b1;
      case (in_tuser)
        ACT_INSERT: begin
          out_valid_nxt = 1'b1;
          if (count_r >= CNT_W'(LIST_DEPTH)) begin
            out_stat_nxt = STAT_FULL;
          end else begin
            ctl.op       = CELL_INS;
            count_nxt    = count_r + 1'b1;
            out_stat_nxt = STAT_INSERTED;
          end
        end
        ACT_DRAIN: begin
          if (count_r == '0) begin
            out_valid_nxt = 1'b1;
            out_stat_nxt  = STAT_EMPTY;
          end else begin
            draining_nxt  = 1'b1;
            drain_idx_nxt = '0;
          end
        end
        ACT_CLEAR: begin
          out_valid_nxt = 1'b1;
          count_nxt     = '0;
          out_stat_nxt  = STAT_EMPTY;
        end
        default: begin
          out_valid_nxt = out_valid_r && !out_tready;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      draining_r  <= 1'b0;
      drain_idx_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      draining_r  <= draining_nxt;
      drain_idx_r <= drain_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_ent_r  <= out_ent_nxt;
    out_stat_r <= out_stat_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_ent_r.distance, out_ent_r.tag};
  assign out_tuser  = out_stat_r;
  assign out_tlast  = out_last_r;

  // The chain of cells, head at index zero.
  for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
    logic   occ_i;
    logic   wrap_i;
    logic   keep_prev_i;
    entry_t left_i;
    entry_t right_i;

    assign occ_i  = CNT_W'(i) < count_r;
    assign wrap_i = CNT_W'(i) == count_r - 1'b1;

    if (i == 0) begin : g_head
      assign keep_prev_i = 1'b1;
      assign left_i      = cell_q[i];
    end else begin : g_body
      assign keep_prev_i = keep[i-1];
      assign left_i      = cell_q[i-1];
    end

    if (i == LIST_DEPTH - 1) begin : g_tail
      assign right_i = cell_q[0];
    end else begin : g_mid
      assign right_i = cell_q[i+1];
    end

    dsil_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .occ       (occ_i),
      .wrap      (wrap_i),
      .keep_prev (keep_prev_i),
      .left_q    (left_i),
      .right_q   (right_i),
      .head_q    (cell_q[0]),
      .q         (cell_q[i]),
      .keep      (keep[i])
    );
  end

  // The count never exceeds the list depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(LIST_DEPTH))
    else $error("entry count above list depth");

  // A drain only runs over a non-empty list and stays inside it.
  a_drain_range: assert property (@(posedge clk) disable iff (!rst_n)
    draining_r |-> (count_r != '0) && (drain_idx_r < count_r))
    else $error("drain index out of range");

  // An accepted clear leaves the list empty.
  a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_tuser == ACT_CLEAR) |=> (count_r == '0))
    else $error("clear did not empty the list");

  // The count does not change while a drain runs.
  a_drain_count: assert property (@(posedge clk) disable iff (!rst_n)
    (draining_r && $past(draining_r)) |-> $stable(count_r))
    else $error("count changed during a drain");

endmodule

// ----- verif/dsil_list_checker.sv -----
// Checker for the depth-sorted insertion list: watches both stream channels,
// keeps its own copy of the sorted table and compares every result item.
// Depends on dsil_pkg.
module dsil_list_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  input  logic                        in_tready,
  input  logic [dsil_pkg::DATA_W-1:0] in_tdata,   // [15:0] entry_tag, [47:16] entry_distance
  input  logic [dsil_pkg::ACT_W-1:0]  in_tuser,   // [1:0] action
  input  logic                        out_tvalid,
  input  logic                        out_tready,
  input  logic [dsil_pkg::DATA_W-1:0] out_tdata,  // [15:0] out_tag, [47:16] out_distance
  input  logic [dsil_pkg::STAT_W-1:0] out_tuser,  // [1:0] status
  input  logic                        out_tlast,
  output int                          fail_count,
  output int                          pending_results
);
  import dsil_pkg::*;

  typedef struct {
    logic [TAG_W-1:0]         tag;
    logic signed [DIST_W-1:0] distance;
    logic [STAT_W-1:0]        status;
    logic                     last;
  } list_result_t;

  // Shadow of the sorted table, farthest entry first.
  entry_t       shadow_list [LIST_DEPTH];
  int           shadow_count = 0;
  list_result_t awaited_results [$];
  int           failures = 0;
  list_result_t want;

  // Queues one result item that the list is expected to produce.
  task automatic await_result(input logic [TAG_W-1:0] tag,
                              input logic [DIST_W-1:0] distance,
                              input logic [STAT_W-1:0] status, input logic last);
    list_result_t r;
    r.tag      = tag;
    r.distance = distance;
    r.status   = status;
    r.last     = last;
    awaited_results.push_back(r);
  endtask

  // Applies one accepted item to the shadow table and queues its results.
  task automatic apply_list_action(input logic [ACT_W-1:0] action,
                                   input logic [TAG_W-1:0] tag,
                                   input logic signed [DIST_W-1:0] distance);
    int slot;
    int n;
    case (action)
      ACT_INSERT: begin
        if (shadow_count >= LIST_DEPTH) begin
          await_result('0, '0, STAT_FULL, 1'b1);
        end else begin
          // The new entry goes behind every entry at the same or a greater distance.
          slot = 0;
          while (slot < shadow_count && shadow_list[slot].distance >= distance) slot++;
          for (int i = shadow_count; i > slot; i--) shadow_list[i] = shadow_list[i-1];
          shadow_list[slot].tag      = tag;
          shadow_list[slot].distance = distance;
          shadow_count++;
          await_result('0, '0, STAT_INSERTED, 1'b1);
        end
      end
      ACT_DRAIN: begin
        if (shadow_count == 0) begin
          await_result('0, '0, STAT_EMPTY, 1'b1);
        end else begin
          n = (shadow_count > RESULT_LIMIT) ? RESULT_LIMIT : shadow_count;
          for (int i = 0; i < n; i++)
            await_result(shadow_list[i].tag, shadow_list[i].distance, STAT_ENTRY,
                         i == n - 1);
        end
      end
      ACT_CLEAR: begin
        shadow_count = 0;
        await_result('0, '0, STAT_EMPTY, 1'b1);
      end
      default: begin
        // The unused action code leaves the list alone and produces nothing.
      end
    endcase
  endtask

  // Counts a failure; only the first few are described.
  task automatic report_failure(input string what);
    failures++;
    if (failures <= 10)
      $display("[%0t] %s: got tag %h dist %0d status %0d last %b", $realtime, what,
               out_tdata[15:0], $signed(out_tdata[47:16]), out_tuser, out_tlast);
  endtask

  // Results are checked before the input of the same edge is applied, as a
  // result can never stem from an item accepted at that very edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      shadow_count = 0;
      awaited_results.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (awaited_results.size() == 0) begin
          report_failure("result with nothing awaited");
        end else begin
          want = awaited_results.pop_front();
          if (out_tdata[15:0] !== want.tag || out_tdata[47:16] !== want.distance ||
              out_tuser !== want.status || out_tlast !== want.last)
            report_failure($sformatf("mismatch, expected tag %h dist %0d status %0d last %b",
                                     want.tag, want.distance, want.status, want.last));
        end
      end
      if (in_tvalid && in_tready)
        apply_list_action(in_tuser, in_tdata[15:0], in_tdata[47:16]);
    end
    fail_count      <= failures;
    pending_results <= awaited_results.size();
  end

endmodule

// ----- verif/tb_top.sv -----
// Top of the depth-sorted insertion list testbench: clock, reset, stimulus and
// the final verdict. Depends on dsil_pkg, depth_sorted_insert_list and dsil_list_checker.
module tb_top;
  import dsil_pkg::*;

  localparam logic [ACT_W-1:0] ACT_UNUSED  = 2'd3;
  localparam int               ITEM_TARGET = 310;
  localparam int               CYCLE_LIMIT = 500000;
  localparam int               SETTLE      = 40;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [DATA_W-1:0] in_tdata;   // [15:0] entry_tag, [47:16] entry_distance
  logic [ACT_W-1:0]  in_tuser;   // [1:0] action
  logic              out_tvalid;
  logic              out_tready;
  logic [DATA_W-1:0] out_tdata;  // [15:0] out_tag, [47:16] out_distance
  logic [STAT_W-1:0] out_tuser;  // [1:0] status
  logic              out_tlast;
  int                fail_count;
  int                pending_results;

  bit calm = 1'b0;
  int items_sent = 0;
  int cycle_count = 0;
  int ready_hold = 0;
  int ready_gap;

  depth_sorted_insert_list dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  dsil_list_checker list_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser),
    .out_tlast       (out_tlast),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  always #10 clk = ~clk;

  // Idle cycles before an item; none during a calm stretch.
  function automatic int draw_gap();
    return calm ? 0 : int'($urandom_range(0, 4));
  endfunction

  function automatic logic [TAG_W-1:0] random_tag();
    return TAG_W'($urandom_range(0, 16'hFFFF));
  endfunction

  // Mixes the extremes, a narrow band that forces ties, and the full range.
  function automatic logic [DIST_W-1:0] random_distance();
    case ($urandom_range(0, 4))
      0:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      1:       return 32'($urandom_range(0, 6)) - 32'd3;
      default: return $urandom;
    endcase
  endfunction

  // Offers one item after a random gap and holds it until it is taken.
  task automatic send_item(input logic [ACT_W-1:0] action, input logic [TAG_W-1:0] tag,
                           input logic [DIST_W-1:0] distance);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= action;
    in_tdata  <= {distance, tag};
    do @(posedge clk); while (!in_tready);
    if (action != ACT_UNUSED) items_sent++;
  endtask

  // The result side stalls for a freshly drawn number of cycles after each item.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      ready_hold <= 0;
    end else if (ready_hold > 1) begin
      ready_hold <= ready_hold - 1;
    end else if (ready_hold == 1) begin
      ready_hold <= 0;
      out_tready <= 1'b1;
    end else if (out_tvalid && out_tready) begin
      ready_gap = draw_gap();
      if (ready_gap > 0) begin
        out_tready <= 1'b0;
        ready_hold <= ready_gap;
      end
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL depth_sorted_insert_list");
      $finish;
    end
  end

  initial begin
    int kind;
    int fill;
    int seq_no;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= ACT_INSERT;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: empty list, both distance extremes, ties, the unused code.
    send_item(ACT_DRAIN,  16'h0000, 32'h0000_0000);
    send_item(ACT_CLEAR,  16'hFFFF, 32'hFFFF_FFFF);
    send_item(ACT_INSERT, 16'h0000, 32'h7FFF_FFFF);
    send_item(ACT_INSERT, 16'hFFFF, 32'h8000_0000);
    send_item(ACT_INSERT, 16'h1234, 32'h0000_0000);
    send_item(ACT_INSERT, 16'h0005, 32'h0000_0000);
    send_item(ACT_INSERT, 16'h0006, 32'h7FFF_FFFF);
    send_item(ACT_INSERT, 16'h0007, 32'hFFFF_FFFF);
    send_item(ACT_INSERT, 16'h0008, 32'h8000_0000);
    send_item(ACT_UNUSED, 16'hA5A5, 32'h5A5A_5A5A);
    send_item(ACT_DRAIN,  16'hFFFF, 32'hFFFF_FFFF);
    send_item(ACT_DRAIN,  16'h0000, 32'h0000_0000);
    send_item(ACT_CLEAR,  16'h0000, 32'h0000_0000);
    send_item(ACT_DRAIN,  16'h0000, 32'h0000_0000);
    send_item(ACT_INSERT, 16'h4321, 32'h0000_0001);
    send_item(ACT_DRAIN,  16'h0000, 32'h0000_0000);
    send_item(ACT_CLEAR,  16'h0000, 32'h0000_0000);

    // Random part: mostly fill-and-drain runs, the first one filling the table and usually overfilling it.
    seq_no = 0;
    while (items_sent < ITEM_TARGET) begin
      kind = (seq_no == 0) ? 5 : $urandom_range(0, 9);
      calm = ($urandom_range(0, 4) == 0);
      if (kind <= 5) begin
        if ($urandom_range(0, 3) != 0) send_item(ACT_CLEAR, random_tag(), random_distance());
        fill = (kind == 5) ? $urandom_range(32, 36) : $urandom_range(1, 12);
        for (int k = 0; k < fill; k++) begin
          send_item(ACT_INSERT, random_tag(), random_distance());
          if ($urandom_range(0, 15) == 0) send_item(ACT_DRAIN, random_tag(), random_distance());
        end
        send_item(ACT_DRAIN, random_tag(), random_distance());
      end else if (kind <= 7) begin
        repeat ($urandom_range(1, 6))
          send_item(ACT_W'($urandom_range(0, 3)), random_tag(), random_distance());
      end else if (kind == 8) begin
        send_item(ACT_DRAIN, random_tag(), random_distance());
      end else begin
        send_item(ACT_CLEAR, random_tag(), random_distance());
        send_item(ACT_DRAIN, random_tag(), random_distance());
      end
      seq_no++;
    end
    in_tvalid <= 1'b0;
    calm = 1'b0;

    // Let the checker take in the last item, drain what is awaited, then settle.
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (fail_count == 0 && pending_results == 0) begin
      $display("PASS depth_sorted_insert_list");
    end else begin
      $display("FAIL depth_sorted_insert_list");
    end
    $finish;
  end

endmodule

// ----- depth_sorted_insert_list.f -----
hw/rtl/dsil_pkg.sv
hw/rtl/dsil_cell.sv
hw/rtl/depth_sorted_insert_list.sv
verif/dsil_list_checker.sv
verif/tb_top.sv
